/* sv/key_click_classifier_macros.svh */
// assertion macros for the key click classifier
`ifndef KEY_CLICK_CLASSIFIER_MACROS_SVH
`define KEY_CLICK_CLASSIFIER_MACROS_SVH

`ifndef NO_ASSERTIONS

// clocked check, quiet while reset is applied
`define KCC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define KCC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define KCC_ASSERT(lbl, prop, msg)
`define KCC_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

/* sv/kcc_pkg.sv */
// types and constants shared by the key click classifier modules
package kcc_pkg;

	localparam int NUM_KEYS = 2;
	localparam int KEY_W  = 1;
	localparam int CFG_W  = 16;
	localparam int TIME_W = 32;

	localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd500;
	localparam logic [CFG_W-1:0] DOUBLE_TAP_RESET = 16'd200;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_CHECK = 2'd1,
		PH_WAIT2 = 2'd2,
		PH_HELD  = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		EV_NONE   = 2'd0,
		EV_SINGLE = 2'd1,
		EV_DOUBLE = 2'd2,
		EV_LONG   = 2'd3
	} click_event_t;

	typedef enum logic [0:0] {
		REG_LONG_PRESS = 1'b0,
		REG_DOUBLE_TAP = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic [KEY_W-1:0]  key_index;
		logic              pressed;
		logic [TIME_W-1:0] now_ms;
	} kcc_in_t;

	typedef struct packed {
		logic [KEY_W-1:0] out_key;
		click_event_t     click_event;
	} kcc_out_t;

	typedef struct packed {
		logic [CFG_W-1:0] long_press_ms;
		logic [CFG_W-1:0] double_tap_ms;
	} kcc_cfg_t;

	typedef struct packed {
		phase_t            phase;
		logic [TIME_W-1:0] start_ms;
	} key_state_t;

	typedef struct packed {
		logic             we;
		logic [KEY_W-1:0] key;
		key_state_t       st;
	} key_upd_t;

endpackage

/* sv/kcc_cfg_regs.sv */
// threshold registers written through the plain configuration port
module kcc_cfg_regs (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  kcc_pkg::cfg_idx_t       cfg_index,
	input  logic [kcc_pkg::CFG_W-1:0] cfg_data,
	output kcc_pkg::kcc_cfg_t       cfg
);
	import kcc_pkg::*;

	logic [CFG_W-1:0] long_press_ms_q;
	logic [CFG_W-1:0] double_tap_ms_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_press_ms_q <= LONG_PRESS_RESET;
			double_tap_ms_q <= DOUBLE_TAP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LONG_PRESS: long_press_ms_q <= cfg_data;
				REG_DOUBLE_TAP: double_tap_ms_q <= cfg_data;
			endcase
		end
	end

	assign cfg.long_press_ms = long_press_ms_q;
	assign cfg.double_tap_ms = double_tap_ms_q;

endmodule

/* sv/kcc_key_bank.sv */
// per-key phase and start time registers with select and write-back
module kcc_key_bank (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [kcc_pkg::KEY_W-1:0] rd_key,
	output kcc_pkg::key_state_t       rd_state,
	output logic                      rd_ok,
	input  kcc_pkg::key_upd_t         upd
);
	import kcc_pkg::*;

	key_state_t state_q [NUM_KEYS];

	// keys are matched by full-width compare so unreachable entries never alias
	always_comb begin
		rd_state = '{phase: PH_IDLE, start_ms: '0};
		rd_ok    = 1'b0;
		for (int i = 0; i < NUM_KEYS; i++) begin
			if (i == int'(rd_key)) begin
				rd_state = state_q[i];
				rd_ok    = 1'b1;
			end
		end
	end

	for (genvar g = 0; g < NUM_KEYS; g++) begin : g_key
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				state_q[g] <= '{phase: PH_IDLE, start_ms: '0};
			end else if (upd.we && (g == int'(upd.key))) begin
				state_q[g] <= upd.st;
			end
		end
	end

endmodule

/* sv/kcc_step.sv */
// one scan sample through the per-key click phase machine
module kcc_step (
	input  kcc_pkg::kcc_in_t    req,
	input  kcc_pkg::key_state_t cur,
	input  kcc_pkg::kcc_cfg_t   cfg,
	output kcc_pkg::key_state_t nxt,
	output kcc_pkg::click_event_t click_event
);
	import kcc_pkg::*;

	logic [TIME_W-1:0] elapsed;
	logic              long_hit;
	logic              tap_hit;

	// wrapping difference
	assign elapsed  = req.now_ms - cur.start_ms;
	assign long_hit = elapsed >= {{(TIME_W-CFG_W){1'b0}}, cfg.long_press_ms};
	assign tap_hit  = elapsed >= {{(TIME_W-CFG_W){1'b0}}, cfg.double_tap_ms};

	// next phase and start time
	always_comb begin
		nxt = cur;
		unique case (cur.phase)
			PH_IDLE: begin
				if (req.pressed) begin
					nxt.phase    = PH_CHECK;
					nxt.start_ms = req.now_ms;
				end
			end
			PH_CHECK: begin
				if (!req.pressed) begin
					nxt.phase    = PH_WAIT2;
					nxt.start_ms = req.now_ms;
				end else if (long_hit) begin
					nxt.phase = PH_HELD;
				end
			end
			PH_WAIT2: begin
				if (req.pressed) begin
					nxt.phase = PH_HELD;
				end else if (tap_hit) begin
					nxt.phase = PH_IDLE;
				end
			end
			PH_HELD: begin
				if (!req.pressed) begin
					nxt.phase = PH_IDLE;
				end
			end
		endcase
	end

	// reported event
	always_comb begin
		click_event = EV_NONE;
		unique case (cur.phase)
			PH_CHECK: begin
				if (req.pressed && long_hit) begin
					click_event = EV_LONG;
				end
			end
			PH_WAIT2: begin
				if (req.pressed) begin
					click_event = EV_DOUBLE;
				end else if (tap_hit) begin
					click_event = EV_SINGLE;
				end
			end
			PH_IDLE, PH_HELD: click_event = EV_NONE;
		endcase
	end

endmodule

/* sv/key_click_classifier.sv */
// top level of the key click classifier
//
// usage: each request on the in channel is one scan sample of one key (index,
// pressed level, free-running millisecond count). each sample yields exactly
// one result on the out channel: the key index and a click event (none,
// single click, double click or long press).
// both channels use valid/stall; a request moves when valid is high and stall
// is low. in_stall rises only while a sample sits in the input register and
// the result register is full and stalled.
// an accepted sample goes through the input and the result register to out_data.
// throughput: one sample per cycle unless the receiver stalls, set by the
// single read-modify-write of the per-key phase registers between the input
// and result registers. while the receiver stalls, the result holds and one
// more sample waits in the input register; after that in_stall goes high.
// the thresholds are written through cfg_we/cfg_index/cfg_data; the user must
// write them only while no sample is in flight, the block does not enforce it.
// reset: both registers empty, every key idle with a zero start time,
// long press 500 ms, double tap window 200 ms.
// samples for a key index at or above NUM_KEYS change nothing and report none.
module key_click_classifier (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  kcc_pkg::kcc_in_t          in_data,
	output logic                      out_valid,
	input  logic                      out_stall,
	output kcc_pkg::kcc_out_t         out_data,
	input  logic                      cfg_we,
	input  kcc_pkg::cfg_idx_t         cfg_index,
	input  logic [kcc_pkg::CFG_W-1:0] cfg_data
);
	import kcc_pkg::*;

	`include "key_click_classifier_macros.svh"

	// input register
	logic       valid_s1;
	kcc_in_t    req_s1;

	// result register
	logic       out_valid_q;
	kcc_out_t   out_data_q;

	logic         advance;
	kcc_cfg_t     cfg;
	key_state_t   cur_state;
	logic         key_ok;
	key_state_t   nxt_state;
	click_event_t step_event;
	key_upd_t     upd;
	logic         event_seen;

	// the result register frees up when empty or taken this cycle
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_s1 <= in_data;
		end
	end

	kcc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	kcc_key_bank u_bank (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_key   (req_s1.key_index),
		.rd_state (cur_state),
		.rd_ok    (key_ok),
		.upd      (upd)
	);

	kcc_step u_step (
		.req         (req_s1),
		.cur         (cur_state),
		.cfg         (cfg),
		.nxt         (nxt_state),
		.click_event (step_event)
	);

	// write back in the same cycle the result is registered, so the next
	// sample of the same key already sees the new phase
	assign upd.we  = valid_s1 && advance && key_ok;
	assign upd.key = req_s1.key_index;
	assign upd.st  = nxt_state;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_data_q.out_key     <= req_s1.key_index;
			out_data_q.click_event <= key_ok ? step_event : EV_NONE;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// a shown result that carries a real event
	assign event_seen = out_valid_q && (out_data_q.click_event != EV_NONE);

	// stall is raised only for a waiting sample
	`KCC_ASSERT_ALWAYS(a_stall_needs_sample, in_stall |-> valid_s1, "in_stall without a sample")

	// a blocked sample stays put in the input register
	`KCC_ASSERT(a_s1_holds, in_stall |=> valid_s1 && $stable(req_s1), "blocked sample lost")

	// a sample that moves on always lands in the result register
	`KCC_ASSERT(a_s1_to_out, (valid_s1 && advance) |=> out_valid_q, "sample dropped between registers")

	// events come only from keys that exist
	`KCC_ASSERT(a_event_key, event_seen |-> int'(out_data_q.out_key) < NUM_KEYS, "bad event key")

endmodule

/* tb/key_click_checker.sv */
// checker that predicts the click event of every scan sample and compares it with the block
module key_click_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_stall,
	input  kcc_pkg::kcc_in_t          in_data,
	input  logic                      out_valid,
	input  logic                      out_stall,
	input  kcc_pkg::kcc_out_t         out_data,
	input  logic                      cfg_we,
	input  kcc_pkg::cfg_idx_t         cfg_index,
	input  logic [kcc_pkg::CFG_W-1:0] cfg_data,
	output int                        fail_count,
	output int                        pending_events
);
	import kcc_pkg::*;

	localparam int KEY_COUNT = NUM_KEYS;

	phase_t            key_phase   [KEY_COUNT];
	logic [TIME_W-1:0] phase_start [KEY_COUNT];
	logic [CFG_W-1:0]  long_ms;
	logic [CFG_W-1:0]  tap_ms;
	kcc_out_t          expected_events [$];
	kcc_out_t          want;
	int                errors;

	// advances the phase of one key and returns the event it reports
	function automatic kcc_out_t classify_sample(input kcc_in_t s);
		kcc_out_t          r;
		logic [TIME_W-1:0] elapsed;
		int                k;
		k = int'(s.key_index);
		r.out_key = s.key_index;
		r.click_event = EV_NONE;
		// a key that does not exist changes nothing
		if (k >= KEY_COUNT)
			return r;
		elapsed = s.now_ms - phase_start[k];
		case (key_phase[k])
			PH_IDLE: begin
				if (s.pressed) begin
					phase_start[k] = s.now_ms;
					key_phase[k] = PH_CHECK;
				end
			end
			PH_CHECK: begin
				if (!s.pressed) begin
					phase_start[k] = s.now_ms;
					key_phase[k] = PH_WAIT2;
				end else if (elapsed >= long_ms) begin
					r.click_event = EV_LONG;
					key_phase[k] = PH_HELD;
				end
			end
			PH_WAIT2: begin
				if (s.pressed) begin
					r.click_event = EV_DOUBLE;
					key_phase[k] = PH_HELD;
				end else if (elapsed >= tap_ms) begin
					r.click_event = EV_SINGLE;
					key_phase[k] = PH_IDLE;
				end
			end
			default: begin
				if (!s.pressed)
					key_phase[k] = PH_IDLE;
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < KEY_COUNT; k++) begin
				key_phase[k] = PH_IDLE;
				phase_start[k] = '0;
			end
			long_ms = LONG_PRESS_RESET;
			tap_ms = DOUBLE_TAP_RESET;
			expected_events.delete();
			errors = 0;
			fail_count <= 0;
			pending_events <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_LONG_PRESS: long_ms = cfg_data;
					REG_DOUBLE_TAP: tap_ms = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				expected_events.push_back(classify_sample(in_data));
			if (out_valid && !out_stall) begin
				if (expected_events.size() == 0) begin
					errors++;
					$display("%0t: unexpected result: expected none, actual key %0d event %0d",
						$time, out_data.out_key, out_data.click_event);
				end else begin
					want = expected_events.pop_front();
					if (out_data.out_key !== want.out_key) begin
						errors++;
						$display("%0t: out_key mismatch: expected %0d, actual %0d",
							$time, want.out_key, out_data.out_key);
					end
					if (out_data.click_event !== want.click_event) begin
						errors++;
						$display("%0t: click_event mismatch: expected %0d, actual %0d",
							$time, want.click_event, out_data.click_event);
					end
				end
			end
			fail_count <= errors;
			pending_events <= expected_events.size();
		end
	end

endmodule

/* tb/key_click_classifier_test.sv */
// testbench top for the key click classifier: stimulus, stall pattern and verdict
module key_click_classifier_test;
	import kcc_pkg::*;

	typedef enum {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_TOGGLE
	} stall_mode_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	kcc_in_t           in_data = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	kcc_out_t          out_data;
	logic              cfg_we = 1'b0;
	cfg_idx_t          cfg_index = REG_LONG_PRESS;
	logic [CFG_W-1:0]  cfg_data = '0;
	int                fail_count;
	int                pending_events;

	// sender burst bookkeeping and the per-key time and level of the random part
	int                burst_left = 0;
	logic [TIME_W-1:0] key_clock [2];
	logic              key_level [2];

	// receiver stall pattern state
	stall_mode_t       stall_mode = STALL_NONE;
	int                mode_left = 0;

	always #10 clk = ~clk;

	key_click_classifier dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	key_click_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_data        (in_data),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_data       (out_data),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.fail_count     (fail_count),
		.pending_events (pending_events)
	);

	// receiver: draws a new stall mode whenever mode_left runs out, so that
	// long free-running stretches alternate with light, heavy and toggling stalls
	always @(posedge clk) begin
		if (mode_left == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
			mode_left <= $urandom_range(16, 64);
		end else begin
			mode_left <= mode_left - 1;
		end
		case (stall_mode)
			STALL_NONE:   out_stall <= 1'b0;
			STALL_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
			default:      out_stall <= ~out_stall;
		endcase
	end

	// one request on the in channel; valid stays high into the next request
	// while the burst lasts, otherwise the sender drops it for a random gap
	task automatic send_sample(input logic key, input logic down, input logic [TIME_W-1:0] t);
		kcc_in_t s;
		s.key_index = key;
		s.pressed = down;
		s.now_ms = t;
		in_data <= s;
		in_valid <= 1'b1;
		// in_stall read here is the value seen by the edge just passed
		do @(posedge clk); while (in_stall);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
			// mostly short bursts, now and then a long one with no gaps at all
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) :
				$urandom_range(0, 6);
		end
	endtask

	// sender pauses until every predicted event has come out, plus the pipe depth
	task automatic drain_events();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_events != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		burst_left = 0;
	endtask

	// writes both thresholds on consecutive edges, block idle
	task automatic set_thresholds(input logic [CFG_W-1:0] hold, input logic [CFG_W-1:0] tap);
		cfg_we <= 1'b1;
		cfg_index <= REG_LONG_PRESS;
		cfg_data <= hold;
		@(posedge clk);
		cfg_index <= REG_DOUBLE_TAP;
		cfg_data <= tap;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// time step that lands within two counts of a threshold
	function automatic logic [TIME_W-1:0] around(input logic [CFG_W-1:0] x);
		int unsigned j;
		j = $urandom_range(0, 4);
		if (x + j < 2)
			return '0;
		return x + j - 2;
	endfunction

	// random press and release sequences: each key keeps its own level and
	// clock, the steps cluster around both thresholds so every decision is hit
	// from both sides, and a few raw 32-bit jumps act as noise (wraps and
	// counts that go backward)
	task automatic random_phase(input int n, input logic [CFG_W-1:0] hold,
			input logic [CFG_W-1:0] tap);
		int                i;
		int                pick;
		logic              key;
		logic [TIME_W-1:0] step;
		for (i = 0; i < n; i++) begin
			key = 1'($urandom_range(0, 1));
			pick = $urandom_range(0, 99);
			if (pick < 35)
				step = $urandom_range(0, 3);
			else if (pick < 55)
				step = around(hold);
			else if (pick < 75)
				step = around(tap);
			else if (pick < 95)
				step = $urandom_range(0, 2 * hold + 4);
			else
				step = $urandom();
			key_clock[key] = key_clock[key] + step;
			if ($urandom_range(0, 99) < 45)
				key_level[key] = ~key_level[key];
			send_sample(key, key_level[key], key_clock[key]);
		end
	endtask

	initial begin
		key_clock[0] = $urandom();
		key_clock[1] = $urandom();
		key_level[0] = 1'b0;
		key_level[1] = 1'b0;

		// reset once, released on a rising edge
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset thresholds: long press 500, double tap window 200
		// double click on key 0, then held until release
		send_sample(1'b0, 1'b1, 32'd0);
		send_sample(1'b0, 1'b0, 32'd50);
		send_sample(1'b0, 1'b1, 32'd100);
		send_sample(1'b0, 1'b1, 32'd150);
		send_sample(1'b0, 1'b0, 32'd160);
		// long press on key 1 across the wrap of the count, one short then exact
		send_sample(1'b1, 1'b1, 32'hFFFF_FF00);
		send_sample(1'b1, 1'b1, 32'h0000_00F3);
		send_sample(1'b1, 1'b1, 32'h0000_00F4);
		send_sample(1'b1, 1'b0, 32'hFFFF_FFFF);
		// single click on key 0: window one short, then exactly met
		send_sample(1'b0, 1'b1, 32'd1000);
		send_sample(1'b0, 1'b0, 32'd1010);
		send_sample(1'b0, 1'b0, 32'd1209);
		send_sample(1'b0, 1'b0, 32'd1210);
		// count going backward reads as a huge hold time
		send_sample(1'b1, 1'b1, 32'd5000);
		send_sample(1'b1, 1'b1, 32'd4999);
		send_sample(1'b1, 1'b0, 32'd0);
		drain_events();

		// zero thresholds decide on the very next sample of the key
		set_thresholds(16'd0, 16'd0);
		send_sample(1'b0, 1'b1, 32'd7);
		send_sample(1'b0, 1'b1, 32'd7);
		send_sample(1'b0, 1'b0, 32'd8);
		send_sample(1'b1, 1'b1, 32'd9);
		send_sample(1'b1, 1'b0, 32'd9);
		send_sample(1'b1, 1'b0, 32'd9);
		drain_events();

		// largest thresholds
		set_thresholds(16'hFFFF, 16'hFFFF);
		send_sample(1'b0, 1'b1, 32'd0);
		send_sample(1'b0, 1'b1, 32'd65534);
		send_sample(1'b0, 1'b1, 32'd65535);
		send_sample(1'b0, 1'b0, 32'd1);
		drain_events();

		// random part, one threshold setting per phase
		set_thresholds(LONG_PRESS_RESET, DOUBLE_TAP_RESET);
		random_phase(150, LONG_PRESS_RESET, DOUBLE_TAP_RESET);
		drain_events();
		set_thresholds(16'd0, 16'hFFFF);
		random_phase(120, 16'd0, 16'hFFFF);
		drain_events();
		set_thresholds(16'hFFFF, 16'd0);
		random_phase(120, 16'hFFFF, 16'd0);
		drain_events();
		begin
			logic [CFG_W-1:0] hold;
			logic [CFG_W-1:0] tap;
			hold = CFG_W'($urandom_range(1, 40));
			tap = CFG_W'($urandom_range(1, 40));
			set_thresholds(hold, tap);
			random_phase(160, hold, tap);
			drain_events();
			hold = CFG_W'($urandom());
			tap = CFG_W'($urandom());
			set_thresholds(hold, tap);
			random_phase(100, hold, tap);
			drain_events();
		end
		set_thresholds(16'd3, 16'd7);
		random_phase(200, 16'd3, 16'd7);

		// wait out every pending event and the pipe behind it
		drain_events();
		repeat (8) @(posedge clk);
		if (fail_count == 0) begin
			$display("key_click_classifier verification clean");
		end else begin
			$display("key_click_classifier verification failed");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#5000000;
		$display("key_click_classifier verification failed");
		$finish;
	end

endmodule
